// ===== src/rle_pkg.sv =====
package rle_pkg;

  // run counter width; longest run is 2^COUNT_WIDTH - 1
  localparam int COUNT_WIDTH = 16;

  // decimal digits needed for the largest count (floor(n*log10(2)) + 1)
  localparam int DIGITS   = (COUNT_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W    = DIGITS * 4;
  localparam int DIG_IW   = $clog2(DIGITS);
  localparam int SHIFT_CW = $clog2(COUNT_WIDTH + 1);

  // text characters
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // converter status toward the sequencer
  typedef struct packed {
    logic              busy;
    logic [DIG_IW-1:0] msd;   // index of the most significant nonzero digit
  } bcd_stat_t;

  // bytes that need a backslash in front
  function automatic logic needs_escape(input logic [7:0] c);
    return (c == CH_COLON) || (c == CH_BAR) || (c == CH_BSLASH);
  endfunction

endpackage

// ===== src/rle_text_encoder.sv =====
// Run-length text encoder. Token bytes come in one word at a time, with
// in_token_end on the last byte of a token; each finished run goes out as
// "<decimal length>:<byte>", runs of a token parted by '|', and ':', '|'
// or '\' bytes escaped with '\'. A byte that only extends or opens a run is
// taken and yields nothing. A byte that closes one or two runs holds
// in_stall high until the last character is in the output register: per
// run, the binary-to-BCD converter is loaded and runs its add-3/shift
// steps, then the characters (3 to 9) go out one by one, held while
// out_stall is high. The output register lets the last character
// wait while the next word is taken in.
module rle_text_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_token_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_token_done,
  output logic       out_burst_end
);

  localparam int CW = rle_pkg::COUNT_WIDTH;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CONV  = 7'b0000010,
    ST_BAR   = 7'b0000100,
    ST_DIGIT = 7'b0001000,
    ST_COLON = 7'b0010000,
    ST_ESC   = 7'b0100000,
    ST_SYM   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // open run
  logic          active_r, active_nxt;
  logic [7:0]    sym_r, sym_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          first_r, first_nxt;

  // run being printed
  logic [7:0] cur_sym_r, cur_sym_nxt;
  logic       cur_bar_r, cur_bar_nxt;
  logic       cur_tok_r, cur_tok_nxt;
  logic       cur_fin_r, cur_fin_nxt;

  // second run of the same word
  logic          pend_valid_r, pend_valid_nxt;
  logic [7:0]    pend_sym_r, pend_sym_nxt;
  logic [CW-1:0] pend_len_r, pend_len_nxt;

  logic [rle_pkg::DIG_IW-1:0] dig_idx_r, dig_idx_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_tok_r, out_tok_nxt;
  logic       out_end_r, out_end_nxt;

  // converter
  logic                        conv_start;
  logic [CW-1:0]               conv_value;
  logic [rle_pkg::BCD_W-1:0]   conv_digits;
  rle_pkg::bcd_stat_t          conv_stat;

  logic accept, extend, emit_prev, out_free;

  rle_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (conv_start),
    .value  (conv_value),
    .digits (conv_digits),
    .stat   (conv_stat)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign extend   = active_r && (in_data_byte == sym_r) && (len_r != '1);
  assign emit_prev = active_r && !extend;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    sym_nxt        = sym_r;
    len_nxt        = len_r;
    first_nxt      = first_r;
    cur_sym_nxt    = cur_sym_r;
    cur_bar_nxt    = cur_bar_r;
    cur_tok_nxt    = cur_tok_r;
    cur_fin_nxt    = cur_fin_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    pend_len_nxt   = pend_len_r;
    dig_idx_nxt    = dig_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_tok_nxt    = out_tok_r;
    out_end_nxt    = out_end_r;
    conv_start     = 1'b0;
    conv_value     = len_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (emit_prev) begin
            // close the open run first; a token end queues the new one
            cur_sym_nxt    = sym_r;
            cur_bar_nxt    = !first_r;
            cur_tok_nxt    = 1'b0;
            cur_fin_nxt    = !in_token_end;
            conv_value     = len_r;
            conv_start     = 1'b1;
            pend_valid_nxt = in_token_end;
            pend_sym_nxt   = in_data_byte;
            pend_len_nxt   = CW'(1);
            state_nxt      = ST_CONV;
          end else if (in_token_end) begin
            cur_sym_nxt = in_data_byte;
            cur_bar_nxt = !first_r;
            cur_tok_nxt = 1'b1;
            cur_fin_nxt = 1'b1;
            conv_value  = extend ? (len_r + 1'b1) : CW'(1);
            conv_start  = 1'b1;
            state_nxt   = ST_CONV;
          end
          // run state update
          if (in_token_end) begin
            active_nxt = 1'b0;
            sym_nxt    = '0;
            len_nxt    = '0;
            first_nxt  = 1'b1;
          end else if (extend) begin
            len_nxt = len_r + 1'b1;
          end else begin
            active_nxt = 1'b1;
            sym_nxt    = in_data_byte;
            len_nxt    = CW'(1);
            if (emit_prev) begin
              first_nxt = 1'b0;
            end
          end
        end
      end
      ST_CONV: begin
        if (!conv_stat.busy) begin
          dig_idx_nxt = conv_stat.msd;
          state_nxt   = cur_bar_r ? ST_BAR : ST_DIGIT;
        end
      end
      ST_BAR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rle_pkg::CH_BAR;
          out_tok_nxt   = 1'b0;
          out_end_nxt   = 1'b0;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rle_pkg::CH_ZERO | {4'd0, conv_digits[dig_idx_r*4 +: 4]};
          out_tok_nxt   = 1'b0;
          out_end_nxt   = 1'b0;
          if (dig_idx_r == '0) begin
            state_nxt = ST_COLON;
          end else begin
            dig_idx_nxt = dig_idx_r - 1'b1;
          end
        end
      end
      ST_COLON: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rle_pkg::CH_COLON;
          out_tok_nxt   = 1'b0;
          out_end_nxt   = 1'b0;
          state_nxt     = rle_pkg::needs_escape(cur_sym_r) ? ST_ESC : ST_SYM;
        end
      end
      ST_ESC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rle_pkg::CH_BSLASH;
          out_tok_nxt   = 1'b0;
          out_end_nxt   = 1'b0;
          state_nxt     = ST_SYM;
        end
      end
      ST_SYM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = cur_sym_r;
          out_tok_nxt   = cur_tok_r;
          out_end_nxt   = cur_fin_r;
          if (pend_valid_r) begin
            // token's last run follows the one just closed
            cur_sym_nxt    = pend_sym_r;
            cur_bar_nxt    = 1'b1;
            cur_tok_nxt    = 1'b1;
            cur_fin_nxt    = 1'b1;
            conv_value     = pend_len_r;
            conv_start     = 1'b1;
            pend_valid_nxt = 1'b0;
            state_nxt      = ST_CONV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      active_r     <= 1'b0;
      sym_r        <= '0;
      len_r        <= '0;
      first_r      <= 1'b1;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      sym_r        <= sym_nxt;
      len_r        <= len_nxt;
      first_r      <= first_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_sym_r  <= cur_sym_nxt;
    cur_bar_r  <= cur_bar_nxt;
    cur_tok_r  <= cur_tok_nxt;
    cur_fin_r  <= cur_fin_nxt;
    pend_sym_r <= pend_sym_nxt;
    pend_len_r <= pend_len_nxt;
    dig_idx_r  <= dig_idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_tok_r  <= out_tok_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_token_done = out_tok_r;
  assign out_burst_end  = out_end_r;

endmodule

// ===== src/rle_bcd.sv =====
// Iterative binary to BCD converter: one add-3 / shift step per cycle.
module rle_bcd (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [rle_pkg::COUNT_WIDTH-1:0] value,
  output logic [rle_pkg::BCD_W-1:0]       digits,
  output rle_pkg::bcd_stat_t              stat
);

  logic [rle_pkg::COUNT_WIDTH-1:0] bin_r;
  logic [rle_pkg::BCD_W-1:0]       bcd_r;
  logic [rle_pkg::BCD_W-1:0]       adj;
  logic [rle_pkg::SHIFT_CW-1:0]    cnt_r;

  // add 3 to every digit of 5 or more ahead of the shift
  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < rle_pkg::DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= rle_pkg::SHIFT_CW'(rle_pkg::COUNT_WIDTH);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // shift datapath
  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= value;
      bcd_r <= '0;
    end else if (cnt_r != '0) begin
      bcd_r <= {adj[rle_pkg::BCD_W-2:0], bin_r[rle_pkg::COUNT_WIDTH-1]};
      bin_r <= {bin_r[rle_pkg::COUNT_WIDTH-2:0], 1'b0};
    end
  end

  // leading digit search over the finished result
  always_comb begin
    stat.busy = (cnt_r != '0);
    stat.msd  = '0;
    for (int i = 0; i < rle_pkg::DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        stat.msd = i[rle_pkg::DIG_IW-1:0];
      end
    end
  end

  assign digits = bcd_r;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // one expected character of encoded text
  typedef struct packed {
    logic [7:0] ch;
    logic       token_done;
    logic       burst_end;
  } enc_char_t;

  // Tracks the open run, predicts the text each word yields, checks output words
  class run_text_scoreboard;
    bit                            run_open;
    bit [7:0]                      run_sym;
    bit [rle_pkg::COUNT_WIDTH-1:0] run_len;
    bit                            token_fresh;
    bit [7:0]                      burst_text[$];
    enc_char_t                     expected_text[$];
    int                            mismatches;

    function new();
      run_open    = 1'b0;
      run_sym     = '0;
      run_len     = '0;
      token_fresh = 1'b1;
      mismatches  = 0;
    endfunction

    // append "<len>:<byte>" for the open run, '|' first unless it opens the token
    function void close_run();
      string digits;
      digits = $sformatf("%0d", run_len);
      if (!token_fresh) burst_text.push_back(rle_pkg::CH_BAR);
      for (int i = 0; i < digits.len(); i++) burst_text.push_back(digits[i]);
      burst_text.push_back(rle_pkg::CH_COLON);
      if (run_sym == rle_pkg::CH_COLON || run_sym == rle_pkg::CH_BAR ||
          run_sym == rle_pkg::CH_BSLASH)
        burst_text.push_back(rle_pkg::CH_BSLASH);
      burst_text.push_back(run_sym);
      token_fresh = 1'b0;
    endfunction

    function void note_word(bit [7:0] b, bit last);
      enc_char_t c;
      burst_text.delete();
      // extend the run unless the byte differs or the counter is full
      if (run_open && b == run_sym && run_len != '1) begin
        run_len++;
      end else begin
        if (run_open) close_run();
        run_open = 1'b1;
        run_sym  = b;
        run_len  = rle_pkg::COUNT_WIDTH'(1);
      end
      if (last) begin
        close_run();
        run_open    = 1'b0;
        run_sym     = '0;
        run_len     = '0;
        token_fresh = 1'b1;
      end
      foreach (burst_text[k]) begin
        c.ch         = burst_text[k];
        c.burst_end  = (k == burst_text.size() - 1);
        c.token_done = last && c.burst_end;
        expected_text.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic done, logic burst);
      enc_char_t want;
      if (expected_text.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: byte %h done %b burst %b", ch, done, burst);
        mismatches++;
        return;
      end
      want = expected_text.pop_front();
      if (ch !== want.ch || done !== want.token_done || burst !== want.burst_end) begin
        if (mismatches < 10)
          $display("mismatch: expected byte %h done %b burst %b, got byte %h done %b burst %b",
                   want.ch, want.token_done, want.burst_end, ch, done, burst);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_token_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_token_done;
  logic       out_burst_end;

  bit in_gaps    = 1'b0;
  int stall_pct  = 0;
  int stall_left = 0;

  run_text_scoreboard board;

  rle_text_encoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_token_end   (in_token_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_token_done (out_token_done),
    .out_burst_end  (out_burst_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver stalls in bursts of random length, started at a rate set by stall_pct
  always @(posedge clk) begin
    if (stall_left != 0) stall_left--;
    else if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
    out_stall <= (stall_left != 0);
  end

  // check every accepted output word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_char(out_byte, out_token_done, out_burst_end);
  end

  // one input word, with an optional idle burst in front
  task automatic send_word(input logic [7:0] b, input logic last);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_token_end <= last;
    do @(posedge clk); while (in_stall);
    board.note_word(b, last);
  endtask

  // n copies of one byte; token_end on the final one if asked
  task automatic send_run(input logic [7:0] b, input int n, input logic last);
    for (int i = 0; i < n; i++) send_word(b, last && (i == n - 1));
  endtask

  initial begin
    int         sent;
    int         len;
    bit         noisy;
    bit         tail;
    logic [7:0] cur;
    logic [7:0] alpha[3];

    board = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    in_token_end <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-byte tokens at the byte extremes and the escaped bytes
    in_gaps   = 1'b1;
    stall_pct = 20;
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(rle_pkg::CH_COLON, 1'b1);
    send_word(rle_pkg::CH_BAR, 1'b1);
    send_word(rle_pkg::CH_BSLASH, 1'b1);
    // runs closed by a differing byte, then by the token end
    send_run(8'h61, 3, 1'b0);
    send_word(8'h62, 1'b1);
    // token end that extends the open run
    send_word(8'h78, 1'b0);
    send_run(8'h79, 2, 1'b1);
    // separators between escaped runs
    send_word(rle_pkg::CH_COLON, 1'b0);
    send_word(rle_pkg::CH_BAR, 1'b0);
    send_word(rle_pkg::CH_BSLASH, 1'b1);
    send_word(8'h55, 1'b0);
    send_run(8'hAA, 3, 1'b1);

    // random tokens, mostly runs from a small alphabet, some pure noise
    sent = 0;
    while (sent < 430) begin
      tail      = (sent >= 370);
      in_gaps   = !tail && ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        default: stall_pct = 50;
      endcase
      if (tail) stall_pct = 0;
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      noisy = ($urandom_range(0, 4) == 0);
      alpha[0] = 8'($urandom);
      alpha[1] = 8'($urandom);
      case ($urandom_range(0, 2))
        0:       alpha[2] = rle_pkg::CH_COLON;
        1:       alpha[2] = rle_pkg::CH_BAR;
        default: alpha[2] = rle_pkg::CH_BSLASH;
      endcase
      cur = alpha[$urandom_range(0, 2)];
      for (int i = 0; i < len; i++) begin
        if (noisy) cur = 8'($urandom);
        else if ($urandom_range(0, 2) == 0) cur = alpha[$urandom_range(0, 2)];
        send_word(cur, i == len - 1);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // drain, then allow a stray late word to show up
    while (board.expected_text.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.mismatches == 0 && board.expected_text.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rle_pkg.sv
src/rle_bcd.sv
src/rle_text_encoder.sv
verif/tb.sv
